/* rtl/fdc_pkg.sv */
// Shared types and constants of the floppy drive controller.
// Used by the drive engine, the top level and the testbench.
package fdc_pkg;

  // Sector limit checked by the start commands and default sector size
  parameter int unsigned SECTOR_COUNT = 2048;
  parameter int unsigned SECTOR_BYTES = 512;

  // Timing register defaults
  parameter logic [31:0] SPIN_UP_TIME_RST    = 32'd8000000;
  parameter logic [31:0] SPIN_DOWN_DELAY_RST = 32'd16000000;
  parameter logic [31:0] BLINK_PERIOD_RST    = 32'd2000000;
  parameter logic [15:0] BYTE_PERIOD_RST     = 16'd256;

  typedef enum logic [2:0] {
    MODE_EMPTY    = 3'd0,
    MODE_LOADED   = 3'd1,
    MODE_SPINUP   = 3'd2,
    MODE_READING  = 3'd3,
    MODE_WRITING  = 3'd4,
    MODE_SPINNING = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    ERR_NONE          = 4'd0,
    ERR_NO_DISK       = 4'd1,
    ERR_BAD_SECTOR    = 4'd2,
    ERR_READ_PLANNED  = 4'd3,
    ERR_WRITE_PLANNED = 4'd4,
    ERR_BUSY_READ     = 4'd5,
    ERR_BUSY_WRITE    = 4'd6,
    ERR_PROTECTED     = 4'd7,
    ERR_SPINNING      = 4'd8
  } err_e;

  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_TICK   = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_EJECT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_SPIN_UP_TIME    = 2'd0,
    CFG_SPIN_DOWN_DELAY = 2'd1,
    CFG_BLINK_PERIOD    = 2'd2,
    CFG_BYTE_PERIOD     = 2'd3
  } cfg_idx_e;

  // Register window
  parameter logic [3:0] REG_STATUS  = 4'd0;
  parameter logic [3:0] REG_CMD     = 4'd1;
  parameter logic [3:0] REG_ERROR   = 4'd2;
  parameter int unsigned REG_SECTOR = 4;
  parameter int unsigned REG_BUFFER = 8;
  parameter logic [3:0] REG_BUF_LOW = 4'd11;

  // Command bytes
  parameter logic [7:0] CMD_READ      = 8'b0000_0100;
  parameter logic [7:0] CMD_WRITE     = 8'b0000_1000;
  parameter logic [7:0] CMD_CLEAR_ERR = 8'b1000_0000;
  parameter logic [7:0] BUF_LOW_MASK  = 8'b1111_1110;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  reg_address;
    logic [7:0]  write_data;
    logic [15:0] tick_cycles;
    logic        protect_flag;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        event_failed;
    logic        xfer_valid;
    logic        xfer_to_disk;
    logic [19:0] disk_offset;
    logic [23:0] ram_address;
    logic        led_lit;
    logic [2:0]  drive_mode;
  } rsp_t;

  typedef struct packed {
    logic [31:0] spin_up_time;
    logic [31:0] spin_down_delay;
    logic [31:0] blink_period;
    logic [15:0] byte_period;
  } cfg_t;

endpackage

/* rtl/fdc_chan_if.sv */
// Valid/ready channel carrying one payload of type T per transaction.
// No dependencies; instantiated with the payload types of fdc_pkg.
interface fdc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/floppy_drive_controller.sv */
// Top level of the floppy drive controller: channels, timing registers,
// input and result registers. Depends on fdc_pkg, fdc_chan_if, fdc_engine.
//
// Usage: req_i carries bus reads and writes, ticks with an elapsed cycle
// count, and disk insert/eject events. Every request transaction yields
// exactly one result transaction on rsp_o with the read byte, the event
// status, an optional sector byte transfer (disk offset / RAM address), the
// error LED and the drive mode after the request.
// The timing registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i
// while no request is in flight; the user must keep to this, the block
// does not enforce it. A request is held in the input register, and when
// it advances its result is registered into rsp_q, which drives rsp_o.
// Throughput: one request per cycle while the receiver takes the results,
// as fdc_engine updates the drive state once for each advancing request.
// Reset clears the drive to empty with no error and LED off, and loads the
// timing registers with their defaults. When the receiver stalls, the
// result holds and the input register keeps one more request; beyond that
// req_i.ready drops until the result is taken.
module floppy_drive_controller #(
  parameter int unsigned SectorBytes = fdc_pkg::SECTOR_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  fdc_chan_if.sink    req_i,
  fdc_chan_if.source  rsp_o
);
  import fdc_pkg::*;

  cfg_t cfg_q;
  req_t req_q;
  logic req_valid_q;
  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q;
  logic advance;

  // Advance when the held request can drop its result into a free slot
  assign advance     = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spin_up_time    <= SPIN_UP_TIME_RST;
      cfg_q.spin_down_delay <= SPIN_DOWN_DELAY_RST;
      cfg_q.blink_period    <= BLINK_PERIOD_RST;
      cfg_q.byte_period     <= BYTE_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SPIN_UP_TIME:    cfg_q.spin_up_time    <= cfg_wdata_i;
        CFG_SPIN_DOWN_DELAY: cfg_q.spin_down_delay <= cfg_wdata_i;
        CFG_BLINK_PERIOD:    cfg_q.blink_period    <= cfg_wdata_i;
        CFG_BYTE_PERIOD:     cfg_q.byte_period     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        req_valid_q <= req_i.valid;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q <= req_i.data;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  fdc_engine #(
    .SectorBytes (SectorBytes)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (req_q),
    .cfg_i  (cfg_q),
    .rsp_o  (rsp_d)
  );

endmodule

/* rtl/fdc_engine.sv */
// Drive state, register file, timers and LED logic of the drive controller.
// Depends on fdc_pkg; one transaction is processed per fire_i cycle.
module fdc_engine #(
  parameter int unsigned SectorBytes = fdc_pkg::SECTOR_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  fdc_pkg::req_t req_i,
  input  fdc_pkg::cfg_t cfg_i,
  output fdc_pkg::rsp_t rsp_o
);
  import fdc_pkg::*;

  localparam int BcW   = $clog2(SectorBytes + 1);
  localparam int ProdW = (16 + BcW > 20) ? 16 + BcW : 20;

  mode_e            mode_q, mode_d;
  mode_e            planned_q, planned_d;
  logic [31:0]      accum_q, accum_d;
  logic [BcW-1:0]   byte_count_q, byte_count_d;
  logic [15:0]      sector_q, sector_d;
  logic [23:0]      buffer_q, buffer_d;
  logic [7:0]       reg_file_q [16];
  logic [7:0]       reg_file_d [16];
  err_e             error_q, error_d;
  logic             led_q, led_d;
  logic [31:0]      blink_q, blink_d;
  logic             protected_q, protected_d;

  logic [31:0]      sec_word;
  logic             sec_ok;
  logic [31:0]      acc_sum, acc_limit, acc_rem;
  logic             acc_over;
  logic [31:0]      blink_base;
  logic [BcW-1:0]   bc_inc;
  logic [ProdW-1:0] sec_base, off_sum;
  logic [7:0]       status;
  logic             start_req, err_raise, do_latch;
  mode_e            start_tgt;
  err_e             err_new;

  assign sec_word = {reg_file_q[REG_SECTOR], reg_file_q[REG_SECTOR + 1],
                     reg_file_q[REG_SECTOR + 2], reg_file_q[REG_SECTOR + 3]};
  assign sec_ok   = sec_word < 32'(SECTOR_COUNT);

  // Shared accumulator: add the tick, compare against the limit of this mode
  always_comb begin
    case (mode_q)
      MODE_SPINUP:                 acc_limit = cfg_i.spin_up_time;
      MODE_READING, MODE_WRITING:  acc_limit = {16'd0, cfg_i.byte_period};
      MODE_SPINNING:               acc_limit = cfg_i.spin_down_delay;
      default:                     acc_limit = '0;
    endcase
  end

  assign acc_sum    = accum_q + 32'(req_i.tick_cycles);
  assign acc_over   = acc_sum > acc_limit;
  assign acc_rem    = acc_sum - acc_limit;
  assign blink_base = (blink_q > cfg_i.blink_period) ? blink_q - cfg_i.blink_period : blink_q;
  assign bc_inc     = byte_count_q + BcW'(1);
  assign sec_base   = ProdW'(sector_q) * ProdW'(SectorBytes);
  assign off_sum    = sec_base + ProdW'(byte_count_q);

  always_comb begin
    status    = '0;
    status[0] = mode_q != MODE_EMPTY;
    status[1] = mode_q inside {[MODE_SPINUP:MODE_SPINNING]};
    status[2] = mode_q == MODE_READING;
    status[3] = mode_q == MODE_WRITING;
    status[7] = error_q != ERR_NONE;
  end

  always_comb begin
    mode_d       = mode_q;
    planned_d    = planned_q;
    accum_d      = accum_q;
    byte_count_d = byte_count_q;
    sector_d     = sector_q;
    buffer_d     = buffer_q;
    reg_file_d   = reg_file_q;
    error_d      = error_q;
    led_d        = led_q;
    blink_d      = blink_q;
    protected_d  = protected_q;
    rsp_o        = '0;
    start_req    = 1'b0;
    start_tgt    = MODE_READING;
    err_raise    = 1'b0;
    err_new      = ERR_NONE;
    do_latch     = 1'b0;

    case (req_i.kind)
      KIND_READ: begin
        case (req_i.reg_address)
          REG_STATUS: rsp_o.read_data = status;
          REG_CMD:    rsp_o.read_data = '0;
          REG_ERROR:  rsp_o.read_data = {4'd0, error_q};
          default:    rsp_o.read_data = reg_file_q[req_i.reg_address];
        endcase
      end
      KIND_WRITE: begin
        if (req_i.reg_address == REG_CMD) begin
          case (req_i.write_data)
            CMD_READ: begin
              start_req = 1'b1;
              start_tgt = MODE_READING;
            end
            CMD_WRITE: begin
              // Write protect wins over every other check
              if (protected_q) begin
                err_raise = 1'b1;
                err_new   = ERR_PROTECTED;
              end else begin
                start_req = 1'b1;
                start_tgt = MODE_WRITING;
              end
            end
            CMD_CLEAR_ERR: begin
              error_d = ERR_NONE;
              led_d   = 1'b0;
            end
            default: ;
          endcase
        end else if (req_i.reg_address == REG_BUF_LOW) begin
          reg_file_d[req_i.reg_address] = req_i.write_data & BUF_LOW_MASK;
        end else if (req_i.reg_address != REG_STATUS) begin
          reg_file_d[req_i.reg_address] = req_i.write_data;
        end
      end
      KIND_TICK: begin
        case (mode_q)
          MODE_SPINUP: begin
            accum_d = acc_sum;
            if (acc_over) begin
              mode_d    = planned_q;
              planned_d = MODE_SPINNING;
              accum_d   = acc_rem;
            end
          end
          MODE_READING, MODE_WRITING: begin
            accum_d = acc_sum;
            if (acc_over) begin
              rsp_o.xfer_valid   = 1'b1;
              rsp_o.xfer_to_disk = mode_q == MODE_WRITING;
              rsp_o.disk_offset  = off_sum[19:0];
              rsp_o.ram_address  = buffer_q + 24'(byte_count_q);
              accum_d            = acc_rem;
              byte_count_d       = bc_inc;
              // Sector done: drop back to idle spinning
              if (bc_inc >= BcW'(SectorBytes)) begin
                mode_d  = MODE_SPINNING;
                accum_d = '0;
              end
            end
          end
          MODE_SPINNING: begin
            accum_d = acc_sum;
            if (acc_over) begin
              mode_d  = MODE_LOADED;
              accum_d = acc_rem;
            end
          end
          default: ;
        endcase
        if (error_q != ERR_NONE) begin
          if (blink_q > cfg_i.blink_period) begin
            led_d = ~led_q;
          end
          blink_d = blink_base + 32'(req_i.tick_cycles);
        end
      end
      KIND_INSERT: begin
        if (mode_q != MODE_EMPTY) begin
          rsp_o.event_failed = 1'b1;
        end else begin
          mode_d      = MODE_SPINUP;
          planned_d   = MODE_SPINNING;
          protected_d = req_i.protect_flag;
        end
      end
      KIND_EJECT: begin
        if (mode_q == MODE_LOADED) begin
          mode_d = MODE_EMPTY;
        end else begin
          rsp_o.event_failed = 1'b1;
          err_raise          = 1'b1;
          err_new            = (mode_q == MODE_EMPTY) ? ERR_NO_DISK : ERR_SPINNING;
        end
      end
      default: ;
    endcase

    if (start_req) begin
      case (mode_q)
        MODE_EMPTY: begin
          err_raise = 1'b1;
          err_new   = ERR_NO_DISK;
        end
        MODE_LOADED: begin
          if (sec_ok) begin
            do_latch  = 1'b1;
            mode_d    = MODE_SPINUP;
            planned_d = start_tgt;
          end else begin
            err_raise = 1'b1;
            err_new   = ERR_BAD_SECTOR;
          end
        end
        MODE_SPINUP: begin
          if (planned_q == MODE_SPINNING) begin
            if (sec_ok) begin
              do_latch  = 1'b1;
              planned_d = start_tgt;
            end else begin
              err_raise = 1'b1;
              err_new   = ERR_BAD_SECTOR;
            end
          end else if (planned_q == MODE_READING) begin
            err_raise = 1'b1;
            err_new   = ERR_READ_PLANNED;
          end else if (planned_q == MODE_WRITING) begin
            err_raise = 1'b1;
            err_new   = ERR_WRITE_PLANNED;
          end
        end
        MODE_READING: begin
          err_raise = 1'b1;
          err_new   = ERR_BUSY_READ;
        end
        MODE_WRITING: begin
          err_raise = 1'b1;
          err_new   = ERR_BUSY_WRITE;
        end
        MODE_SPINNING: begin
          if (sec_ok) begin
            do_latch = 1'b1;
            mode_d   = start_tgt;
          end else begin
            err_raise = 1'b1;
            err_new   = ERR_BAD_SECTOR;
          end
        end
        default: ;
      endcase
    end

    if (do_latch) begin
      sector_d     = sec_word[15:0];
      buffer_d     = {reg_file_q[REG_BUFFER + 1], reg_file_q[REG_BUFFER + 2],
                      reg_file_q[REG_BUFFER + 3]};
      accum_d      = '0;
      byte_count_d = '0;
    end

    // Recording an error lights the LED and restarts the blink timer
    if (err_raise) begin
      error_d = err_new;
      led_d   = 1'b1;
      blink_d = '0;
    end

    rsp_o.led_lit    = led_d;
    rsp_o.drive_mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_EMPTY;
      planned_q    <= MODE_EMPTY;
      accum_q      <= '0;
      byte_count_q <= '0;
      sector_q     <= '0;
      buffer_q     <= '0;
      reg_file_q   <= '{default: '0};
      error_q      <= ERR_NONE;
      led_q        <= 1'b0;
      blink_q      <= '0;
      protected_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q       <= mode_d;
      planned_q    <= planned_d;
      accum_q      <= accum_d;
      byte_count_q <= byte_count_d;
      sector_q     <= sector_d;
      buffer_q     <= buffer_d;
      reg_file_q   <= reg_file_d;
      error_q      <= error_d;
      led_q        <= led_d;
      blink_q      <= blink_d;
      protected_q  <= protected_d;
    end
  end

endmodule

/* bench/floppy_drive_controller_tb.sv */
// Self-checking testbench of floppy_drive_controller: directed and random requests,
// predicted replies checked field by field. Depends on fdc_pkg, fdc_chan_if and the RTL.
module floppy_drive_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdc_pkg::*;

  // Tracks the drive state and holds the replies it predicts
  class drive_tracker;
    logic [31:0] spin_up_lim, spin_down_lim, blink_lim;
    logic [15:0] byte_lim;
    mode_e       mode, planned;
    logic [31:0] accum, blink_cnt;
    int unsigned byte_cnt;
    logic [15:0] sector_q;
    logic [23:0] buffer_q;
    logic [7:0]  regs [16];
    err_e        err;
    bit          led, wp_disk;
    rsp_t        expected_replies [$];
    int unsigned mismatches;

    function new();
      spin_up_lim   = SPIN_UP_TIME_RST;
      spin_down_lim = SPIN_DOWN_DELAY_RST;
      blink_lim     = BLINK_PERIOD_RST;
      byte_lim      = BYTE_PERIOD_RST;
      mode          = MODE_EMPTY;
      planned       = MODE_EMPTY;
      accum         = '0;
      blink_cnt     = '0;
      byte_cnt      = 0;
      sector_q      = '0;
      buffer_q      = '0;
      foreach (regs[i]) regs[i] = '0;
      err           = ERR_NONE;
      led           = 1'b0;
      wp_disk       = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_timing(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_SPIN_UP_TIME:    spin_up_lim = val;
        CFG_SPIN_DOWN_DELAY: spin_down_lim = val;
        CFG_BLINK_PERIOD:    blink_lim = val;
        default:             byte_lim = val[15:0];
      endcase
    endfunction

    function void raise(err_e code);
      err       = code;
      led       = 1'b1;
      blink_cnt = '0;
    endfunction

    function logic [31:0] word_at(int unsigned base);
      return {regs[base], regs[base+1], regs[base+2], regs[base+3]};
    endfunction

    function bit latch_target();
      logic [31:0] sec, buf_w;
      sec = word_at(REG_SECTOR);
      if (sec >= SECTOR_COUNT) begin
        raise(ERR_BAD_SECTOR);
        return 1'b0;
      end
      buf_w    = word_at(REG_BUFFER);
      sector_q = sec[15:0];
      buffer_q = buf_w[23:0];
      accum    = '0;
      byte_cnt = 0;
      return 1'b1;
    endfunction

    function void start_xfer(mode_e target);
      case (mode)
        MODE_EMPTY: raise(ERR_NO_DISK);
        MODE_LOADED: begin
          if (latch_target()) begin
            mode    = MODE_SPINUP;
            planned = target;
          end
        end
        MODE_SPINUP: begin
          // a transfer can only replace a plain spin-up plan
          if (planned == MODE_SPINNING) begin
            if (latch_target()) planned = target;
          end else if (planned == MODE_READING) begin
            raise(ERR_READ_PLANNED);
          end else if (planned == MODE_WRITING) begin
            raise(ERR_WRITE_PLANNED);
          end
        end
        MODE_READING: raise(ERR_BUSY_READ);
        MODE_WRITING: raise(ERR_BUSY_WRITE);
        MODE_SPINNING: begin
          if (latch_target()) mode = target;
        end
        default: ;
      endcase
    endfunction

    function logic [7:0] read_reg(logic [3:0] a);
      logic [7:0] s;
      s = '0;
      if (a == REG_STATUS) begin
        s[0] = (mode != MODE_EMPTY);
        s[1] = (mode >= MODE_SPINUP && mode <= MODE_SPINNING);
        s[2] = (mode == MODE_READING);
        s[3] = (mode == MODE_WRITING);
        s[7] = (err != ERR_NONE);
        return s;
      end
      if (a == REG_CMD) return '0;
      if (a == REG_ERROR) return {4'd0, err};
      return regs[a];
    endfunction

    function void write_reg(logic [3:0] a, logic [7:0] d);
      if (a == REG_STATUS) return;
      if (a == REG_CMD) begin
        if (d == CMD_READ) begin
          start_xfer(MODE_READING);
        end else if (d == CMD_WRITE) begin
          // write protect wins over every other check
          if (wp_disk) raise(ERR_PROTECTED);
          else start_xfer(MODE_WRITING);
        end else if (d == CMD_CLEAR_ERR) begin
          err = ERR_NONE;
          led = 1'b0;
        end
        return;
      end
      if (a == REG_BUF_LOW) d = d & BUF_LOW_MASK;
      regs[a] = d;
    endfunction

    function void tick(logic [15:0] cyc, inout rsp_t r);
      logic [63:0] off;
      logic [31:0] ram;
      case (mode)
        MODE_SPINUP: begin
          accum += cyc;
          if (accum > spin_up_lim) begin
            mode    = planned;
            planned = MODE_SPINNING;
            accum  -= spin_up_lim;
          end
        end
        MODE_READING, MODE_WRITING: begin
          accum += cyc;
          if (accum > {16'd0, byte_lim}) begin
            off = 64'(sector_q) * 64'(SECTOR_BYTES) + 64'(byte_cnt);
            ram = 32'(buffer_q) + byte_cnt;
            r.xfer_valid   = 1'b1;
            r.xfer_to_disk = (mode == MODE_WRITING);
            r.disk_offset  = off[19:0];
            r.ram_address  = ram[23:0];
            accum -= {16'd0, byte_lim};
            byte_cnt++;
            if (byte_cnt >= SECTOR_BYTES) begin
              mode  = MODE_SPINNING;
              accum = '0;
            end
          end
        end
        MODE_SPINNING: begin
          accum += cyc;
          if (accum > spin_down_lim) begin
            mode   = MODE_LOADED;
            accum -= spin_down_lim;
          end
        end
        default: ;
      endcase
      if (err != ERR_NONE) begin
        // toggle on the count so far, then add this tick
        if (blink_cnt > blink_lim) begin
          led        = !led;
          blink_cnt -= blink_lim;
        end
        blink_cnt += cyc;
      end
    endfunction

    function rsp_t advance(req_t q);
      rsp_t r;
      r = '0;
      case (q.kind)
        KIND_READ:  r.read_data = read_reg(q.reg_address);
        KIND_WRITE: write_reg(q.reg_address, q.write_data);
        KIND_TICK:  tick(q.tick_cycles, r);
        KIND_INSERT: begin
          if (mode != MODE_EMPTY) begin
            r.event_failed = 1'b1;
          end else begin
            mode    = MODE_SPINUP;
            planned = MODE_SPINNING;
            wp_disk = q.protect_flag;
          end
        end
        KIND_EJECT: begin
          if (mode == MODE_EMPTY) begin
            raise(ERR_NO_DISK);
            r.event_failed = 1'b1;
          end else if (mode == MODE_LOADED) begin
            mode = MODE_EMPTY;
          end else begin
            raise(ERR_SPINNING);
            r.event_failed = 1'b1;
          end
        end
        default: ;
      endcase
      r.led_lit    = led;
      r.drive_mode = mode;
      return r;
    endfunction

    function void note_request(req_t q);
      expected_replies.push_back(advance(q));
    endfunction

    function void field_ok(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_reply(rsp_t got);
      rsp_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("reply with nothing pending: %h", got);
        return;
      end
      want = expected_replies.pop_front();
      field_ok("read_data", 24'(got.read_data), 24'(want.read_data));
      field_ok("event_failed", 24'(got.event_failed), 24'(want.event_failed));
      field_ok("xfer_valid", 24'(got.xfer_valid), 24'(want.xfer_valid));
      field_ok("xfer_to_disk", 24'(got.xfer_to_disk), 24'(want.xfer_to_disk));
      field_ok("disk_offset", 24'(got.disk_offset), 24'(want.disk_offset));
      field_ok("ram_address", got.ram_address, want.ram_address);
      field_ok("led_lit", 24'(got.led_lit), 24'(want.led_lit));
      field_ok("drive_mode", 24'(got.drive_mode), 24'(want.drive_mode));
    endfunction

    function int unsigned failures();
      return mismatches + expected_replies.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  fdc_chan_if #(.T(req_t)) req_if ();
  fdc_chan_if #(.T(rsp_t)) rsp_if ();

  drive_tracker ledger;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  bit           want_hold = 1'b0;

  floppy_drive_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] pick_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return 16'hffff;
    if (r < 30) return 16'($urandom);
    return 16'($urandom_range(0, 400));
  endfunction

  function automatic req_t mk_tick();
    req_t q;
    q = '0;
    q.kind        = KIND_TICK;
    q.tick_cycles = pick_cycles();
    return q;
  endfunction

  function automatic req_t mk_start();
    req_t q;
    q = '0;
    q.kind        = KIND_WRITE;
    q.reg_address = REG_CMD;
    q.write_data  = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
    return q;
  endfunction

  function automatic req_t mk_read();
    req_t q;
    q = '0;
    q.kind        = KIND_READ;
    q.reg_address = 4'($urandom);
    return q;
  endfunction

  function automatic req_t mk_simple(logic [2:0] k, logic [7:0] d);
    req_t q;
    q = '0;
    q.kind         = k;
    q.reg_address  = REG_CMD;
    q.write_data   = d;
    q.protect_flag = ($urandom_range(0, 3) == 0);
    return q;
  endfunction

  // Mostly legal sector numbers, a few out of range
  function automatic req_t mk_setup();
    req_t q;
    q = '0;
    q.kind        = KIND_WRITE;
    q.reg_address = 4'($urandom_range(REG_SECTOR, REG_BUFFER + 3));
    q.write_data  = 8'($urandom);
    if (q.reg_address < REG_SECTOR + 2 && $urandom_range(0, 9) != 0)
      q.write_data = '0;
    else if (q.reg_address == REG_SECTOR + 2 && $urandom_range(0, 99) < 85)
      q.write_data = 8'($urandom_range(0, 7));
    return q;
  endfunction

  // Steer by the predicted mode so transfers run to the end of a sector
  function automatic req_t pick_request();
    req_t        q;
    int unsigned r;
    q = '0;
    if ($urandom_range(0, 99) < 8) begin
      q.kind         = 3'($urandom_range(0, 7));
      q.reg_address  = 4'($urandom);
      q.write_data   = 8'($urandom);
      q.tick_cycles  = 16'($urandom);
      q.protect_flag = 1'($urandom);
      return q;
    end
    r = $urandom_range(0, 99);
    case (ledger.mode)
      MODE_EMPTY: begin
        if (r < 70) q = mk_simple(KIND_INSERT, '0);
        else if (r < 85) q = mk_simple(KIND_EJECT, '0);
        else q = mk_read();
      end
      MODE_LOADED: begin
        if (r < 35) q = mk_setup();
        else if (r < 75) q = mk_start();
        else if (r < 85) q = mk_simple(KIND_EJECT, '0);
        else if (r < 93) q = mk_read();
        else q = mk_simple(KIND_WRITE, CMD_CLEAR_ERR);
      end
      MODE_SPINUP: begin
        if (r < 75) q = mk_tick();
        else if (r < 88) q = mk_start();
        else if (r < 94) q = mk_read();
        else q = mk_simple(KIND_EJECT, '0);
      end
      MODE_READING, MODE_WRITING: begin
        if (r < 86) q = mk_tick();
        else if (r < 90) q = mk_start();
        else if (r < 95) q = mk_read();
        else if (r < 98) q = mk_simple(KIND_WRITE, CMD_CLEAR_ERR);
        else q = mk_simple(KIND_EJECT, '0);
      end
      default: begin
        if (r < 35) q = mk_start();
        else if (r < 70) q = mk_tick();
        else if (r < 85) q = mk_setup();
        else if (r < 95) q = mk_read();
        else q = mk_simple(KIND_EJECT, '0);
      end
    endcase
    return q;
  endfunction

  task automatic send_item(input req_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= q;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    ledger.note_request(q);
  endtask

  task automatic put(input logic [2:0] k, input logic [3:0] addr, input logic [7:0] data,
                     input logic [15:0] cyc, input logic prot);
    req_t q;
    q.kind         = k;
    q.reg_address  = addr;
    q.write_data   = data;
    q.tick_cycles  = cyc;
    q.protect_flag = prot;
    send_item(q);
  endtask

  task automatic run_phase(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(pick_request());
    req_if.valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (ledger.expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timing(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    ledger.set_timing(idx, val);
    @(posedge clk_i);
  endtask

  task automatic load_timing(input logic [31:0] up, input logic [31:0] down,
                             input logic [31:0] blink, input logic [15:0] per);
    write_timing(CFG_SPIN_UP_TIME, up);
    write_timing(CFG_SPIN_DOWN_DELAY, down);
    write_timing(CFG_BLINK_PERIOD, blink);
    write_timing(CFG_BYTE_PERIOD, 32'(per));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reply side: random stalls plus one long hold-off on request
  initial begin : reply_sink
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) ledger.check_reply(rsp_if.data);
      if (want_hold && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #(4_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    ledger = new();
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_SPIN_UP_TIME;
    cfg_wdata_i  <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timing: error paths, register quirks, unused kinds
    put(KIND_READ, REG_STATUS, '0, '0, 1'b0);
    put(KIND_EJECT, '0, '0, '0, 1'b0);
    put(KIND_WRITE, REG_CMD, CMD_READ, '0, 1'b0);
    put(KIND_READ, REG_ERROR, '0, '0, 1'b0);
    put(KIND_TICK, '0, '0, 16'hffff, 1'b0);
    put(KIND_WRITE, REG_CMD, CMD_WRITE, '0, 1'b0);
    put(KIND_INSERT, '0, '0, '0, 1'b1);
    put(KIND_INSERT, '0, '0, '0, 1'b0);
    put(KIND_WRITE, REG_CMD, CMD_WRITE, '0, 1'b0);
    put(KIND_EJECT, '0, '0, '0, 1'b0);
    put(KIND_WRITE, REG_BUF_LOW, 8'hff, '0, 1'b0);
    put(KIND_READ, REG_BUF_LOW, '0, '0, 1'b0);
    put(KIND_WRITE, REG_STATUS, 8'hff, '0, 1'b0);
    put(KIND_READ, REG_CMD, '0, '0, 1'b0);
    put(3'd5, '0, '0, '0, 1'b0);
    put(3'd7, 4'hf, 8'hff, 16'hffff, 1'b1);
    put(KIND_WRITE, REG_CMD, 8'h55, '0, 1'b0);
    put(KIND_WRITE, REG_CMD, CMD_CLEAR_ERR, '0, 1'b0);
    req_if.valid <= 1'b0;
    drain_all();

    // Short timers: plan a read during spin-up, hit the strict limits
    load_timing(32'd10, 32'd30, 32'd4, 16'd2);
    put(KIND_WRITE, REG_CMD, CMD_READ, '0, 1'b0);
    put(KIND_WRITE, REG_CMD, CMD_READ, '0, 1'b0);
    put(KIND_TICK, '0, '0, 16'd10, 1'b0);
    put(KIND_TICK, '0, '0, 16'd1, 1'b0);
    put(KIND_TICK, '0, '0, 16'd5, 1'b0);
    put(KIND_WRITE, REG_CMD, CMD_WRITE, '0, 1'b0);
    put(KIND_WRITE, REG_CMD, CMD_READ, '0, 1'b0);
    req_if.valid <= 1'b0;
    drain_all();

    load_timing(32'd1000, 32'd5000, 32'd3000, 16'd100);
    run_phase(700);
    drain_all();

    load_timing('0, '0, '0, '0);
    send_idle_pct = 65;
    run_phase(350);
    drain_all();

    load_timing(32'd40, 32'd300, 32'd700, 16'd20);
    send_idle_pct = 0;
    stall_pct     = 65;
    want_hold     = 1'b1;
    run_phase(300);
    drain_all();

    load_timing(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    send_idle_pct = 14;
    stall_pct     = 14;
    run_phase(120);
    drain_all();

    load_timing($urandom_range(0, 2000), $urandom_range(0, 20000),
                $urandom_range(0, 50000), 16'($urandom_range(0, 400)));
    run_phase(180);
    drain_all();

    repeat (10) @(posedge clk_i);
    if (ledger.failures() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
